FILE: rtl/core/cspp_pkg.sv
// Shared types and constants for the 65816 stack push and pull unit.
package cspp_pkg;

   localparam int STACK_BYTES_DEFAULT = 65536;

   localparam logic [15:0] SP_RESET    = 16'h01FF;
   localparam logic [15:0] SP_INC      = 16'h0001;
   localparam logic [15:0] SP_DEC      = 16'hFFFF;
   localparam logic [15:0] PER_BIAS    = 16'h0003;
   localparam logic [7:0]  EMU_FORCE   = 8'h30;
   localparam logic [7:0]  NZ_CLEAR    = 8'h7D;
   localparam logic [7:0]  FLAG_N      = 8'h80;
   localparam logic [7:0]  FLAG_Z      = 8'h02;
   localparam int          INDEX_BIT   = 4;

   localparam logic [1:0]  STEP_ONE    = 2'd1;
   localparam logic [1:0]  STEP_TWO    = 2'd2;
   localparam logic [1:0]  STEP_THREE  = 2'd3;

   typedef enum logic [3:0] {
      OP_PHA = 4'd0,
      OP_PHB = 4'd1,
      OP_PHD = 4'd2,
      OP_PHK = 4'd3,
      OP_PHP = 4'd4,
      OP_PHX = 4'd5,
      OP_PHY = 4'd6,
      OP_PLA = 4'd7,
      OP_PLB = 4'd8,
      OP_PLD = 4'd9,
      OP_PLP = 4'd10,
      OP_PLX = 4'd11,
      OP_PLY = 4'd12,
      OP_PEA = 4'd13,
      OP_PEI = 4'd14,
      OP_PER = 4'd15
   } op_type;

   typedef struct packed {
      op_type      req_type;
      logic        wide;
      logic [15:0] push_value;
      logic [23:0] program_counter;
      logic        emulation_mode;
      logic [7:0]  status_in;
   } req_item_type;

   typedef struct packed {
      logic [15:0] pulled_value;
      logic [7:0]  status_out;
      logic        truncate_index;
      logic [15:0] stack_pointer_out;
      logic [1:0]  pc_step;
   } rsp_item_type;

endpackage

FILE: rtl/core/cspp_ram.sv
// Generic single-port RAM with a registered read.
module cspp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/core/cspp_seq.sv
// Sequencer, stack pointer and shared pointer adder of the stack unit.
module cspp_seq
   import cspp_pkg::*;
#(
   parameter int STACK_BYTES = STACK_BYTES_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  req_item_type                   in_item,
   output logic                           res_valid,
   input  logic                           res_take,
   output rsp_item_type                   res_item,
   output logic                           ram_we,
   output logic [$clog2(STACK_BYTES)-1:0] ram_addr,
   output logic [7:0]                     ram_wdata,
   input  logic [7:0]                     ram_rdata
);

   localparam int AW = $clog2(STACK_BYTES);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_PUSH = 5'b00010,
      S_PULL = 5'b00100,
      S_PCAP = 5'b01000,
      S_DONE = 5'b10000
   } state_type;

   state_type    state_ff, state_in;
   logic [15:0]  sp_ff, sp_in;
   logic         second_ff, second_in;
   logic         is_push_ff, is_push_in;
   logic         is_word_ff, is_word_in;
   req_item_type item_ff, item_in;
   logic [15:0]  data_ff, data_in;
   logic [7:0]   lo_ff, lo_in;
   logic [7:0]   hi_ff, hi_in;

   logic         accept;
   logic         new_push;
   logic         new_word;
   logic [15:0]  new_data;
   logic [15:0]  sp_sum;
   logic [15:0]  pulled;
   logic         neg;
   logic         zero;
   logic [7:0]   nz_status;
   logic [7:0]   plp_status;

   assign accept = in_valid && in_ready;

   always_comb begin
      new_push = 1'b1;
      new_word = 1'b0;
      new_data = in_item.push_value;
      unique case (in_item.req_type)
         OP_PHA, OP_PHX, OP_PHY: begin
            new_word = in_item.wide;
         end
         OP_PHB: begin
            new_word = 1'b0;
         end
         OP_PHD, OP_PEA, OP_PEI: begin
            new_word = 1'b1;
         end
         OP_PHK: begin
            new_data = {8'h00, in_item.program_counter[23:16]};
         end
         OP_PHP: begin
            new_data = {8'h00, in_item.status_in};
         end
         OP_PLA, OP_PLX, OP_PLY: begin
            new_push = 1'b0;
            new_word = in_item.wide;
         end
         OP_PLB, OP_PLP: begin
            new_push = 1'b0;
         end
         OP_PLD: begin
            new_push = 1'b0;
            new_word = 1'b1;
         end
         OP_PER: begin
            new_word = 1'b1;
            new_data = in_item.program_counter[15:0] + in_item.push_value + PER_BIAS;
         end
         default: begin
            new_push = 1'b1;
         end
      endcase
   end

   assign sp_sum = sp_ff + (is_push_ff ? SP_DEC : SP_INC);

   always_comb begin
      state_in   = state_ff;
      sp_in      = sp_ff;
      second_in  = second_ff;
      is_push_in = is_push_ff;
      is_word_in = is_word_ff;
      item_in    = item_ff;
      data_in    = data_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      ram_we     = 1'b0;
      ram_addr   = sp_ff[AW-1:0];
      ram_wdata  = data_ff[7:0];
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               item_in    = in_item;
               data_in    = new_data;
               is_push_in = new_push;
               is_word_in = new_word;
               second_in  = 1'b0;
               lo_in      = 8'h00;
               hi_in      = 8'h00;
               state_in   = new_push ? S_PUSH : S_PULL;
            end
         end
         S_PUSH: begin
            ram_we    = 1'b1;
            ram_wdata = (is_word_ff && !second_ff) ? data_ff[15:8] : data_ff[7:0];
            sp_in     = sp_sum;
            if (is_word_ff && !second_ff) begin
               second_in = 1'b1;
            end else begin
               state_in = S_DONE;
            end
         end
         S_PULL: begin
            ram_addr = sp_sum[AW-1:0];
            sp_in    = sp_sum;
            state_in = S_PCAP;
         end
         S_PCAP: begin
            if (!second_ff) begin
               lo_in = ram_rdata;
            end else begin
               hi_in = ram_rdata;
            end
            if (is_word_ff && !second_ff) begin
               second_in = 1'b1;
               state_in  = S_PULL;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sp_ff    <= SP_RESET;
      end else begin
         state_ff <= state_in;
         sp_ff    <= sp_in;
      end
      second_ff  <= second_in;
      is_push_ff <= is_push_in;
      is_word_ff <= is_word_in;
      item_ff    <= item_in;
      data_ff    <= data_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
   end

   assign pulled     = is_word_ff ? {hi_ff, lo_ff} : {8'h00, lo_ff};
   assign neg        = is_word_ff ? pulled[15] : pulled[7];
   assign zero       = (pulled == 16'h0000);
   assign nz_status  = (item_ff.status_in & NZ_CLEAR) | (neg ? FLAG_N : 8'h00)
                       | (zero ? FLAG_Z : 8'h00);
   assign plp_status = lo_ff | (item_ff.emulation_mode ? EMU_FORCE : 8'h00);

   always_comb begin
      res_item.pulled_value      = is_push_ff ? 16'h0000 : pulled;
      res_item.stack_pointer_out = sp_ff;
      res_item.truncate_index    = 1'b0;
      res_item.status_out        = item_ff.status_in;
      res_item.pc_step           = STEP_ONE;
      unique case (item_ff.req_type)
         OP_PLA, OP_PLB, OP_PLD, OP_PLX, OP_PLY: begin
            res_item.status_out = nz_status;
         end
         OP_PLP: begin
            res_item.status_out     = plp_status;
            res_item.truncate_index = plp_status[INDEX_BIT];
         end
         OP_PEA, OP_PER: begin
            res_item.pc_step = STEP_THREE;
         end
         OP_PEI: begin
            res_item.pc_step = STEP_TWO;
         end
         default: begin
            res_item.pc_step = STEP_ONE;
         end
      endcase
   end

   assign in_ready  = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE);

endmodule

FILE: rtl/core/cpu_stack_push_pull_unit.sv
// Top level of the 65816 stack push and pull unit with its stream ports.
//
// The unit executes one 65816 stack instruction per transaction against a
// byte-wide single-port stack RAM and a 16-bit stack pointer that resets to
// 0x01FF. One shared adder steps the stack pointer by one for every byte,
// and the single RAM port moves one byte per access. A push is accepted in
// the idle state, passes through the write state once per byte and ends in
// the done state, which hands the result to the output register. A pull
// passes through the read and capture states once per byte because of the
// registered RAM read. The input is not ready while an instruction is in
// flight; the output register lets the next instruction start while a
// result still waits. STACK_BYTES must be a power of two; the stack pointer
// addresses the RAM modulo STACK_BYTES. The RAM has no reset and is not
// cleared, so pulls from unwritten bytes return unknown data.
module cpu_stack_push_pull_unit
   import cspp_pkg::*;
#(
   parameter int STACK_BYTES = STACK_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // wide, push_value, program_counter, emulation_mode, status_in
   input  logic [55:0] req_tdata,
   // req_type
   input  logic [3:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // pulled_value, status_out, truncate_index, stack_pointer_out, pc_step
   output logic [47:0] rsp_tdata
);

   localparam int AW = $clog2(STACK_BYTES);

   req_item_type  in_item;
   rsp_item_type  res_item;
   logic          res_valid;
   logic          res_take;
   logic          ram_we;
   logic [AW-1:0] ram_addr;
   logic [7:0]    ram_wdata;
   logic [7:0]    ram_rdata;

   logic          rsp_valid_ff, rsp_valid_in;
   rsp_item_type  rsp_item_ff, rsp_item_in;

   always_comb begin
      in_item.req_type        = op_type'(req_tuser);
      in_item.wide            = req_tdata[0];
      in_item.push_value      = req_tdata[16:1];
      in_item.program_counter = req_tdata[40:17];
      in_item.emulation_mode  = req_tdata[41];
      in_item.status_in       = req_tdata[49:42];
   end

   cspp_seq #(
      .STACK_BYTES (STACK_BYTES)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (in_item),
      .res_valid (res_valid),
      .res_take  (res_take),
      .res_item  (res_item),
      .ram_we    (ram_we),
      .ram_addr  (ram_addr),
      .ram_wdata (ram_wdata),
      .ram_rdata (ram_rdata)
   );

   cspp_ram #(
      .WIDTH (8),
      .DEPTH (STACK_BYTES)
   ) u_stack_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign res_take = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (res_valid && res_take) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = res_item;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b00000,
                        rsp_item_ff.pc_step,
                        rsp_item_ff.stack_pointer_out,
                        rsp_item_ff.truncate_index,
                        rsp_item_ff.status_out,
                        rsp_item_ff.pulled_value};

endmodule
